// File: sv/fdrle_pkg.sv
// Shared types and constants of the fixed-distance RLE decompressor.
// Used by the front end, the queue, the back end and the top level.
`timescale 1ns / 1ps

package fdrle_pkg;

  // History ring and block length.
  localparam int unsigned HistDepth = 64;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned LenW      = 17;
  localparam int unsigned CntW      = 6;

  localparam logic [LenW-1:0] MaxBlock   = 17'd65536;
  localparam logic [LenW-1:0] ZeroWindow = 17'd64;

  // Queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Command held in the top three bits of a control byte.
  typedef enum logic [2:0] {
    CMD_LIT = 3'd0,
    CMD_INC = 3'd1,
    CMD_D1  = 3'd2,
    CMD_D2  = 3'd3,
    CMD_D4  = 3'd4,
    CMD_D16 = 3'd5,
    CMD_D32 = 3'd6,
    CMD_D64 = 3'd7
  } fdrle_cmd_e;

  // One classified input byte as it travels through the queue.
  typedef struct packed {
    logic [7:0]        raw;   // byte as received (literal payload)
    fdrle_cmd_e        cmd;   // command if taken as a control byte
    logic [CntW-1:0]   cnt;   // count 1..32
    logic [HistAw-1:0] span;  // copy distance modulo the ring size
  } fdrle_item_t;

  // Copy distance of each command, taken modulo the history depth.
  function automatic logic [HistAw-1:0] copy_dist(fdrle_cmd_e c);
    logic [HistAw-1:0] d;
    d = '0;
    unique case (c)
      CMD_D1:  d = HistAw'(1);
      CMD_D2:  d = HistAw'(2);
      CMD_D4:  d = HistAw'(4);
      CMD_D16: d = HistAw'(16);
      CMD_D32: d = HistAw'(32);
      CMD_D64: d = HistAw'(64);  // wraps to zero: same ring slot
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/fdrle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fdrle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fdrle_front.sv
// Front end: takes input bytes and classifies each into a queue item.
// Depends on fdrle_pkg.
`timescale 1ns / 1ps

module fdrle_front (
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [7:0]         s_data_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output fdrle_pkg::fdrle_item_t item_o
);

  import fdrle_pkg::*;

  fdrle_cmd_e cmd;

  // Decode the byte as a control byte; the back end decides whether it is one
  assign cmd = fdrle_cmd_e'(s_data_i[7:5]);

  always_comb begin
    item_o.raw  = s_data_i;
    item_o.cmd  = cmd;
    item_o.cnt  = CntW'(s_data_i[4:0]) + CntW'(1);
    item_o.span = copy_dist(cmd);
  end

  // Request goes straight into the queue
  assign s_ready_o = push_ready_i;
  assign push_o    = s_valid_i;

endmodule

// File: sv/fdrle_queue.sv
// Short queue of classified items between front and back end.
// Depends on fdrle_pkg.
`timescale 1ns / 1ps

module fdrle_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   push_ready_o,
  input  fdrle_pkg::fdrle_item_t item_i,
  output logic                   pop_valid_o,
  input  logic                   pop_i,
  output fdrle_pkg::fdrle_item_t item_o
);

  import fdrle_pkg::*;

  fdrle_item_t          slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign item_o       = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/fdrle_back.sv
// Back end: tracks literals, runs commands against the history ring and
// drives the output register. Depends on fdrle_pkg and fdrle_ram.
`timescale 1ns / 1ps

module fdrle_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fdrle_pkg::LenW-1:0] len_i,
  input  logic                       item_valid_i,
  output logic                       pop_o,
  input  fdrle_pkg::fdrle_item_t     item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_o,
  output logic                       out_end_o
);

  import fdrle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_RUN  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_INC,
    SRC_LAST,
    SRC_ZERO,
    SRC_RAM
  } src_e;

  state_e            state_q, state_d;
  src_e              src_q, src_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   lit_q, lit_d;
  logic [7:0]        byte_q, byte_d;
  logic [HistAw-1:0] dist_q, dist_d;
  logic [LenW-1:0]   pc_q, pc_d;
  logic [7:0]        last_q, last_d;
  logic [HistDepth-1:0] vld_q, vld_d;
  logic              rvld_q, rvld_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_end_q, out_end_d;

  logic [LenW-1:0]   eff_len;
  logic [LenW-1:0]   pc_inc;
  logic              slot_free;
  logic              blk_end;
  logic [7:0]        emit_byte;
  logic              re;
  logic [HistAw-1:0] raddr;
  logic              we;
  logic [7:0]        rdata;

  // Clamp the configured length into 1..MaxBlock
  always_comb begin
    eff_len = len_i;
    if (len_i == '0) begin
      eff_len = LenW'(1);
    end else if (len_i > MaxBlock) begin
      eff_len = MaxBlock;
    end
  end

  assign pc_inc    = pc_q + LenW'(1);
  assign blk_end   = (pc_inc >= eff_len);
  assign slot_free = !out_valid_q || out_ready_i;

  // Byte to emit in the current run step
  always_comb begin
    case (src_q)
      SRC_LIT:  emit_byte = byte_q;
      SRC_INC:  emit_byte = last_q + 8'd1;
      SRC_LAST: emit_byte = last_q;
      SRC_ZERO: emit_byte = 8'h00;
      SRC_RAM:  emit_byte = rvld_q ? rdata : 8'h00;
      default:  emit_byte = 8'h00;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    lit_d       = lit_q;
    byte_d      = byte_q;
    dist_d      = dist_q;
    pc_d        = pc_q;
    last_d      = last_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_end_d   = out_end_q;
    pop_o       = 1'b0;
    re          = 1'b0;
    raddr       = pc_q[HistAw-1:0] - dist_q;
    we          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          byte_d = item_i.raw;
          cnt_d  = item_i.cnt;
          dist_d = item_i.span;
          if (lit_q != '0) begin
            // pending literal: pass the byte through
            lit_d   = lit_q - CntW'(1);
            src_d   = SRC_LIT;
            cnt_d   = CntW'(1);
            state_d = S_RUN;
          end else begin
            unique case (item_i.cmd) inside
              CMD_LIT: begin
                lit_d = item_i.cnt;
              end
              CMD_INC: begin
                src_d   = SRC_INC;
                state_d = S_RUN;
              end
              CMD_D1: begin
                src_d   = SRC_LAST;
                state_d = S_RUN;
              end
              CMD_D64: begin
                if (pc_q <= ZeroWindow) begin
                  src_d   = SRC_ZERO;
                  state_d = S_RUN;
                end else begin
                  src_d   = SRC_RAM;
                  state_d = S_PREP;
                end
              end
              CMD_D2, CMD_D4, CMD_D16, CMD_D32: begin
                src_d   = SRC_RAM;
                state_d = S_PREP;
              end
            endcase
          end
        end
      end

      S_PREP: begin
        // prime the registered history read
        re      = 1'b1;
        state_d = S_RUN;
      end

      S_RUN: begin
        if (slot_free) begin
          out_valid_d         = 1'b1;
          out_byte_d          = emit_byte;
          out_end_d           = blk_end;
          out_last_d          = blk_end || (cnt_q == CntW'(1));
          we                  = 1'b1;
          last_d              = emit_byte;
          pc_d                = pc_inc;
          vld_d[pc_q[HistAw-1:0]] = 1'b1;
          if (blk_end) begin
            // end of block: drop the rest of the run, start afresh
            pc_d    = '0;
            lit_d   = '0;
            last_d  = 8'h00;
            vld_d   = '0;
            state_d = S_IDLE;
          end else if (cnt_q == CntW'(1)) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q - CntW'(1);
            if (src_q == SRC_RAM) begin
              re    = 1'b1;
              raddr = pc_inc[HistAw-1:0] - dist_q;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Unwritten entries of this block read as zero
  assign rvld_d = re ? vld_q[raddr] : rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lit_q       <= '0;
      pc_q        <= '0;
      last_q      <= 8'h00;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lit_q       <= lit_d;
      pc_q        <= pc_d;
      last_q      <= last_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    cnt_q      <= cnt_d;
    byte_q     <= byte_d;
    dist_q     <= dist_d;
    rvld_q     <= rvld_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_end_q  <= out_end_d;
  end

  // History ring
  fdrle_ram #(
    .WIDTH (8),
    .DEPTH (HistDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pc_q[HistAw-1:0]),
    .wdata_i (emit_byte),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_end_o   = out_end_q;

endmodule

// File: sv/fixed_distance_rle_decompressor.sv
// Top level of the fixed-distance RLE decompressor.
// Depends on fdrle_pkg, fdrle_front, fdrle_queue and fdrle_back.
`timescale 1ns / 1ps

// Compressed bytes enter on s_axis, one per request, and decompressed bytes
// leave on m_axis. Input is taken whenever the two-entry queue behind the
// front end has room, so the source keeps moving while the back end works.
// The back end handles one queued byte at a time: a literal-announcing
// control byte is only recorded, a literal byte is passed to the output,
// an increment, distance-1 or all-zero run of n bytes goes straight from
// idle to the run state, and a copy out of the 64-byte history RAM first
// passes a prime state for its registered read port; then one byte leaves
// per cycle unless m_axis stalls. The input stalls once two more bytes are
// queued behind a long command. m_axis_tlast marks the last byte produced
// by an input byte, m_axis_tuser the final byte of a block; the history is
// empty again after that byte. The user must write out_length on the cfg
// port while the block is idle; the block itself does not enforce this.
module fixed_distance_rle_decompressor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: out_length
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fdrle_pkg::LenW-1:0] cfg_data_i,
  // compressed input
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] in_byte
  // decompressed output
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast,   // run_last
  output logic                       m_axis_tuser    // [0] block_end
);

  import fdrle_pkg::*;

  logic [LenW-1:0] len_q;
  logic            push;
  logic            push_ready;
  fdrle_item_t     front_item;
  logic            q_valid;
  logic            q_pop;
  fdrle_item_t     q_item;

  // Block length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= MaxBlock;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  fdrle_front u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (front_item)
  );

  fdrle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .item_i       (front_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .item_o       (q_item)
  );

  fdrle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .len_i        (len_q),
    .item_valid_i (q_valid),
    .pop_o        (q_pop),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (m_axis_tuser)
  );

  // A block end always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("block end without run end");

  // The back end never takes from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // An accepted byte is visible in the queue in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> q_valid)
    else $error("accepted byte lost in queue");

endmodule
